// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the gaze window block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GWB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GWB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gwb_pkg.sv =====
// Package with constants, types and helpers of the gaze window block
package gwb_pkg;

  localparam int WIN_LEN   = 30;
  localparam int IDX_W     = $clog2(WIN_LEN);
  localparam int CNT_W     = $clog2(WIN_LEN);
  localparam int RUN_W     = $clog2(WIN_LEN + 1);
  localparam int BND_W     = 5;
  localparam int STEP_W    = 8;
  localparam int MOVE_W    = 9;
  localparam int CMP_W     = (RUN_W > BND_W) ? RUN_W : BND_W;
  localparam int POS_LIMIT = 25;

  localparam logic [1:0] CLASS_NONE  = 2'd0;
  localparam logic [1:0] CLASS_UP    = 2'd1;
  localparam logic [1:0] CLASS_DOWN  = 2'd2;
  localparam logic [1:0] CLASS_LEFT  = 2'd1;
  localparam logic [1:0] CLASS_RIGHT = 2'd2;

  localparam logic [1:0] REG_STEP_SIZE = 2'd0;
  localparam logic [1:0] REG_BLINK_MIN = 2'd1;
  localparam logic [1:0] REG_BLINK_MAX = 2'd2;

  localparam logic [STEP_W-1:0] STEP_SIZE_RST = 8'd4;
  localparam logic [BND_W-1:0]  BLINK_MIN_RST = 5'd10;
  localparam logic [BND_W-1:0]  BLINK_MAX_RST = 5'd20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic shift_in;
    logic scan_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic scan_last;
    logic out_free;
  } status_t;

  function automatic logic signed [MOVE_W-1:0] class_step(
    input logic [1:0]        code,
    input logic [1:0]        neg_code,
    input logic [1:0]        pos_code,
    input logic [STEP_W-1:0] step
  );
    logic signed [MOVE_W-1:0] mag;
    mag = $signed({1'b0, step});
    if (code == neg_code) begin
      return -mag;
    end else if (code == pos_code) begin
      return mag;
    end
    return '0;
  endfunction

endpackage

// ===== hdl/gwb_ctrl.sv =====
// Sequencer that steps the gaze window through accept, scan and emit
module gwb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  gwb_pkg::status_t  sts,
  output gwb_pkg::cmd_t     cmd
);

  gwb_pkg::state_t state_r;
  gwb_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gwb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gwb_pkg::ST_IDLE: begin
        if (in_tvalid && sts.full) begin
          state_nxt = gwb_pkg::ST_SCAN;
        end
      end
      gwb_pkg::ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = gwb_pkg::ST_EMIT;
        end
      end
      gwb_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = gwb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gwb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd.shift_in  = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.load_out  = 1'b0;
    case (state_r)
      gwb_pkg::ST_IDLE: begin
        in_tready    = 1'b1;
        cmd.shift_in = in_tvalid;
      end
      gwb_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      gwb_pkg::ST_EMIT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/gwb_datapath.sv =====
// Window storage, blink scan, settings and output register of the gaze window block
module gwb_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  gwb_pkg::cmd_t                          cmd,
  output gwb_pkg::status_t                       sts,
  input  logic [1:0]                             in_horiz,
  input  logic [1:0]                             in_vert,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_index,
  input  logic [7:0]                             cfg_data,
  input  logic                                   out_tready,
  output logic                                   out_tvalid,
  output logic signed [gwb_pkg::MOVE_W-1:0]      out_move_x,
  output logic signed [gwb_pkg::MOVE_W-1:0]      out_move_y,
  output logic                                   out_blink,
  output logic [1:0]                             out_horiz,
  output logic [1:0]                             out_vert
);

  logic [1:0] win_h_r [gwb_pkg::WIN_LEN];
  logic [1:0] win_v_r [gwb_pkg::WIN_LEN];

  logic [gwb_pkg::CNT_W-1:0]  fill_r;
  logic [gwb_pkg::IDX_W-1:0]  idx_r;
  logic [gwb_pkg::RUN_W-1:0]  run_r;
  logic                       seen_r;
  logic [gwb_pkg::STEP_W-1:0] step_size_r;
  logic [gwb_pkg::BND_W-1:0]  blink_min_r;
  logic [gwb_pkg::BND_W-1:0]  blink_max_r;
  logic                       out_valid_r;

  logic [1:0]                 cur_v;
  logic [gwb_pkg::CMP_W-1:0]  run_ext;
  logic [gwb_pkg::CMP_W-1:0]  pos_ext;
  logic [gwb_pkg::CMP_W-1:0]  min_ext;
  logic [gwb_pkg::CMP_W-1:0]  max_ext;
  logic                       blink_hit;

  assign cur_v   = win_v_r[idx_r];
  assign run_ext = gwb_pkg::CMP_W'(run_r);
  assign pos_ext = gwb_pkg::CMP_W'(idx_r);
  assign min_ext = gwb_pkg::CMP_W'(blink_min_r);
  assign max_ext = gwb_pkg::CMP_W'(blink_max_r);

  assign blink_hit = cmd.scan_step && (cur_v != gwb_pkg::CLASS_UP) &&
                     (run_ext > min_ext) && (run_ext < max_ext) &&
                     (pos_ext > min_ext) &&
                     (pos_ext < gwb_pkg::CMP_W'(gwb_pkg::POS_LIMIT));

  assign sts.full      = (fill_r == gwb_pkg::CNT_W'(gwb_pkg::WIN_LEN - 1));
  assign sts.scan_last = (idx_r == gwb_pkg::IDX_W'(gwb_pkg::WIN_LEN - 1));
  assign sts.out_free  = !out_valid_r || out_tready;

  // shift in at the newest end, clear verticals on a blink
  always_ff @(posedge clk) begin
    if (cmd.shift_in) begin
      for (int k = 0; k < gwb_pkg::WIN_LEN - 1; k++) begin
        win_h_r[k] <= win_h_r[k+1];
        win_v_r[k] <= win_v_r[k+1];
      end
      win_h_r[gwb_pkg::WIN_LEN-1] <= in_horiz;
      win_v_r[gwb_pkg::WIN_LEN-1] <= in_vert;
    end else if (blink_hit) begin
      for (int k = 0; k < gwb_pkg::WIN_LEN; k++) begin
        win_v_r[k] <= gwb_pkg::CLASS_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      idx_r  <= '0;
      run_r  <= '0;
      seen_r <= 1'b0;
    end else begin
      if (cmd.shift_in) begin
        if (!sts.full) begin
          fill_r <= fill_r + 1'b1;
        end
        idx_r  <= '0;
        run_r  <= '0;
        seen_r <= 1'b0;
      end else if (cmd.scan_step) begin
        if (!sts.scan_last) begin
          idx_r <= idx_r + 1'b1;
        end
        if (cur_v == gwb_pkg::CLASS_UP) begin
          run_r <= run_r + 1'b1;
        end else begin
          run_r <= '0;
        end
        if (blink_hit) begin
          seen_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r <= gwb_pkg::STEP_SIZE_RST;
      blink_min_r <= gwb_pkg::BLINK_MIN_RST;
      blink_max_r <= gwb_pkg::BLINK_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gwb_pkg::REG_STEP_SIZE: step_size_r <= cfg_data;
        gwb_pkg::REG_BLINK_MIN: blink_min_r <= cfg_data[gwb_pkg::BND_W-1:0];
        gwb_pkg::REG_BLINK_MAX: blink_max_r <= cfg_data[gwb_pkg::BND_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_move_x <= gwb_pkg::class_step(win_h_r[0], gwb_pkg::CLASS_LEFT,
                                        gwb_pkg::CLASS_RIGHT, step_size_r);
      out_move_y <= gwb_pkg::class_step(win_v_r[0], gwb_pkg::CLASS_UP,
                                        gwb_pkg::CLASS_DOWN, step_size_r);
      out_blink  <= seen_r;
      out_horiz  <= win_h_r[0];
      out_vert   <= win_v_r[0];
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== hdl/gaze_window_blink_and_cursor_step_unit.sv =====
// Top level of the gaze window blink detector and cursor stepper
//
//   channel  direction  handshake            payload
//   in_      slave      in_tvalid/in_tready   tdata: horiz_class, vert_class
//   out_     master     out_tvalid/out_tready tdata: move_x, move_y, oldest classes;
//                                             tuser: blink_seen
//   cfg_     slave      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// While the window fills, an item is taken whenever in_tvalid is high. With a
// full window an item is shifted in, the window is scanned entry by entry, and
// the output register is loaded; no new item is taken until that load.
// A stalled output adds cycles only when the next result is ready before the
// previous one is taken. Reset is synchronous and active low; the window holds
// no valid data after reset and fills again. cfg_ready is always high.
`include "assert_macros.svh"

module gaze_window_blink_and_cursor_step_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] horiz_class, [3:2] vert_class
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [8:0] move_x, [17:9] move_y,
                                  // [19:18] oldest_horiz, [21:20] oldest_vert
  output logic [0:0]  out_tuser,  // [0] blink_seen
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  gwb_pkg::cmd_t    cmd;
  gwb_pkg::status_t sts;

  logic signed [gwb_pkg::MOVE_W-1:0] move_x;
  logic signed [gwb_pkg::MOVE_W-1:0] move_y;
  logic                              blink;
  logic [1:0]                        oldest_h;
  logic [1:0]                        oldest_v;

  assign cfg_ready = 1'b1;

  gwb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gwb_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_horiz   (in_tdata[1:0]),
    .in_vert    (in_tdata[3:2]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_move_x (move_x),
    .out_move_y (move_y),
    .out_blink  (blink),
    .out_horiz  (oldest_h),
    .out_vert   (oldest_v)
  );

  assign out_tdata = {2'b00, oldest_v, oldest_h, move_y, move_x};
  assign out_tuser = blink;

  `GWB_ASSERT_NEXT(a_full_starts_scan, clk, rst_n, in_tvalid && in_tready && sts.full, cmd.scan_step, "full-window transfer did not start a scan")
  `GWB_ASSERT_NEXT(a_scan_blocks_input, clk, rst_n, cmd.scan_step && sts.scan_last, !in_tready, "input taken before result was loaded")
  `GWB_ASSERT_NEXT(a_load_gives_valid, clk, rst_n, cmd.load_out, out_tvalid, "loaded result not presented")
  `GWB_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd.load_out, !out_tvalid || out_tready, "result overwritten before transfer")

endmodule

// ===== bench/gwb_tb_pkg.sv =====
// Scoreboard and cursor step predictor for the gaze window testbench
`timescale 1ns / 1ps

package gwb_tb_pkg;

  import gwb_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [MOVE_W-1:0] move_x;
    logic signed [MOVE_W-1:0] move_y;
    logic                     blink_seen;
    logic [1:0]               oldest_horiz;
    logic [1:0]               oldest_vert;
  } cursor_step_t;

  class cursor_step_scoreboard;
    logic [STEP_W-1:0] step_size;
    logic [BND_W-1:0]  blink_min;
    logic [BND_W-1:0]  blink_max;
    logic [1:0]        win_h [WIN_LEN];
    logic [1:0]        win_v [WIN_LEN];
    int                fill;
    cursor_step_t      pending_steps [$];
    int                failures;

    function new();
      step_size = STEP_SIZE_RST;
      blink_min = BLINK_MIN_RST;
      blink_max = BLINK_MAX_RST;
      fill      = 0;
      failures  = 0;
      foreach (win_h[k]) begin
        win_h[k] = CLASS_NONE;
        win_v[k] = CLASS_NONE;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        REG_STEP_SIZE: step_size = data;
        REG_BLINK_MIN: blink_min = data[BND_W-1:0];
        REG_BLINK_MAX: blink_max = data[BND_W-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [MOVE_W-1:0] axis_step(logic [1:0] code, logic [1:0] neg_code,
                                                 logic [1:0] pos_code);
      if (code == neg_code) return MOVE_W'(-int'(step_size));
      if (code == pos_code) return MOVE_W'(int'(step_size));
      return '0;
    endfunction

    // Slide one sample in; once the window is full, scan for a blink and emit the oldest.
    function void note_sample(logic [1:0] h, logic [1:0] v);
      cursor_step_t s;
      int           run;
      bit           blink;
      if (fill < WIN_LEN - 1) begin
        win_h[fill] = h;
        win_v[fill] = v;
        fill++;
        return;
      end
      win_h[WIN_LEN-1] = h;
      win_v[WIN_LEN-1] = v;
      run   = 0;
      blink = 1'b0;
      for (int i = 0; i < WIN_LEN; i++) begin
        if (win_v[i] == CLASS_UP) begin
          run++;
        end else begin
          if (run > int'(blink_min) && run < int'(blink_max) &&
              i > int'(blink_min) && i < POS_LIMIT) begin
            foreach (win_v[k]) win_v[k] = CLASS_NONE;
            blink = 1'b1;
          end
          run = 0;
        end
      end
      s.oldest_horiz = win_h[0];
      s.oldest_vert  = win_v[0];
      s.blink_seen   = blink;
      s.move_x       = axis_step(win_h[0], CLASS_LEFT, CLASS_RIGHT);
      s.move_y       = axis_step(win_v[0], CLASS_UP, CLASS_DOWN);
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_h[i] = win_h[i+1];
        win_v[i] = win_v[i+1];
      end
      pending_steps = {pending_steps, s};
    endfunction

    function void check_step(cursor_step_t got);
      cursor_step_t want;
      if (pending_steps.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected step: x=%0d y=%0d blink=%0b h=%0d v=%0d",
                   $signed(got.move_x), $signed(got.move_y), got.blink_seen,
                   got.oldest_horiz, got.oldest_vert);
        return;
      end
      want = pending_steps[0];
      pending_steps.delete(0);
      if (got.move_x !== want.move_x || got.move_y !== want.move_y ||
          got.blink_seen !== want.blink_seen || got.oldest_horiz !== want.oldest_horiz ||
          got.oldest_vert !== want.oldest_vert) begin
        failures++;
        if (failures <= 10)
          $display("step mismatch: expected x=%0d y=%0d blink=%0b h=%0d v=%0d,",
                   $signed(want.move_x), $signed(want.move_y), want.blink_seen,
                   want.oldest_horiz, want.oldest_vert,
                   " got x=%0d y=%0d blink=%0b h=%0d v=%0d",
                   $signed(got.move_x), $signed(got.move_y), got.blink_seen,
                   got.oldest_horiz, got.oldest_vert);
      end
    endfunction

    function int pending_count();
      return pending_steps.size();
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
// Top-level testbench of the gaze window blink and cursor step unit
`timescale 1ns / 1ps

module tb_top;

  import gwb_pkg::*;
  import gwb_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  cursor_step_scoreboard sb;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int samples_sent = 0;

  gaze_window_blink_and_cursor_step_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(4, 1);
    if (r < 97) return $urandom_range(40, 5);
    return $urandom_range(120, 41);
  endfunction

  function automatic logic [1:0] any_class();
    return 2'($urandom_range(3, 0));
  endfunction

  function automatic logic [1:0] not_up_class();
    logic [1:0] c;
    c = 2'($urandom_range(2, 0));
    return (c == CLASS_UP) ? 2'd3 : c;
  endfunction

  task automatic send_sample(input logic [1:0] h, input logic [1:0] v);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, v, h};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(h, v);
    samples_sent++;
  endtask

  // Hold the sender, let every step arrive, then wait with the sender idle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] step, input logic [7:0] bmin,
                              input logic [7:0] bmax, input bit poke_spare);
    logic [1:0] idx_q [$];
    logic [7:0] val_q [$];
    idx_q = {REG_STEP_SIZE, REG_BLINK_MIN, REG_BLINK_MAX};
    val_q = {step, bmin, bmax};
    if (poke_spare) begin
      idx_q = {idx_q, REG_SPARE};
      val_q = {val_q, 8'($urandom_range(255, 0))};
    end
    foreach (idx_q[k]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_q[k];
      cfg_data  <= val_q[k];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx_q[k], val_q[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly up-runs sized around the blink bounds with closing stretches, some noise.
  task automatic feed_phase(input int count);
    int target;
    int lo;
    int hi;
    target = samples_sent + count;
    while (samples_sent < target) begin
      if ($urandom_range(9, 0) < 7) begin
        lo = int'(sb.blink_min) + 1;
        hi = int'(sb.blink_max) - 1;
        if (hi > 28) hi = 28;
        if (lo > hi) begin
          lo = 1;
          hi = 26;
        end
        repeat ($urandom_range(hi, lo)) send_sample(any_class(), CLASS_UP);
        repeat ($urandom_range(12, 1)) send_sample(any_class(), not_up_class());
      end else begin
        repeat ($urandom_range(8, 1)) send_sample(any_class(), any_class());
      end
    end
  endtask

  initial begin
    cursor_step_t got;
    int           stall;
    int           taken;
    bit           held;
    out_tready <= 1'b0;
    stall = 0;
    taken = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) begin
        got.move_x       = out_tdata[8:0];
        got.move_y       = out_tdata[17:9];
        got.oldest_horiz = out_tdata[19:18];
        got.oldest_vert  = out_tdata[21:20];
        got.blink_seen   = out_tuser[0];
        sb.check_step(got);
        taken++;
      end
      if (taken == 300 && !held) begin
        held  = 1'b1;
        stall = 400;
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (rx_calm) begin
        out_tready <= 1'b1;
      end else begin
        stall = pick_gap();
        out_tready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  initial begin
    logic [7:0] step_plan [8];
    logic [7:0] min_plan [8];
    logic [7:0] max_plan [8];
    step_plan = '{8'd4, 8'd1, 8'd255, 8'd0, 8'd170, 8'd85, 8'd99, 8'd0};
    min_plan  = '{8'd10, 8'd1, 8'd31, 8'd0, 8'd23, 8'd15, 8'hE5, 8'd0};
    max_plan  = '{8'd20, 8'd31, 8'd31, 8'd2, 8'd30, 8'd10, 8'hF3, 8'd0};
    step_plan[7] = 8'($urandom_range(255, 0));
    min_plan[7]  = 8'($urandom_range(255, 0));
    max_plan[7]  = 8'($urandom_range(255, 0));
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_STEP_SIZE;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int h = 0; h < 4; h++)
      for (int v = 0; v < 4; v++)
        send_sample(2'(h), 2'(v));
    repeat (9) send_sample(any_class(), CLASS_UP);

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        drain();
        program_regs(step_plan[p], min_plan[p], max_plan[p], p == 1);
      end
      tx_calm = ($urandom_range(3, 0) == 0);
      rx_calm = ($urandom_range(3, 0) == 0);
      feed_phase(240);
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    drain();

    if (sb.failures == 0 && sb.pending_count() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
